[hw/rtl/tli_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the table linear interpolator.
// No dependencies; imported by every module of the block except tli_ram.
package tli_pkg;

	// breakpoint table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// fixed field widths
	localparam int DATA_W  = 32;
	localparam int CFG_W   = 9;
	localparam int WORD_W  = 2 * DATA_W;
	localparam int DIV_STEPS = DATA_W;

	// function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// one transaction through the divider chain
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] span;
		logic              neg;
		logic [DATA_W-1:0] y1;
	} div_data_t;

endpackage

[hw/rtl/table_linear_interpolator.sv]
`timescale 1ns / 1ps
// Piecewise linear interpolator over a 256-entry breakpoint table in RAM.
// Load: written to RAM on start, no result. Empty-table query: done follows in the next cycle.
// Query: scan reads one entry per cycle from the RAM port; a clamped result ends the scan,
// and an interpolated one then passes the PREP and MUL states and the 32-cell divider row.
// One query in flight at a time.
// arst_n clears control and entries_in_use; table contents are undefined.
module table_linear_interpolator import tli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              entries_in_use_wr,
	input  logic [CFG_W-1:0]  entries_in_use,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [7:0]        entry_index,
	input  logic [DATA_W-1:0] x_value,
	input  logic [DATA_W-1:0] y_value,
	output logic              done,
	output logic [DATA_W-1:0] y_result,
	output logic              status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    entries_in_use_q;
	logic [CNT_W-1:0]    n_c;
	logic [ADDR_W-1:0]   chk_q;
	logic [ADDR_W-1:0]   raddr;
	logic [ADDR_W-1:0]   waddr;
	logic                we;
	logic [WORD_W-1:0]   rdata;
	logic [DATA_W-1:0]   cur_x;
	logic [DATA_W-1:0]   cur_y;
	logic                is_last;
	logic                is_first;
	logic                above;
	logic                accept;
	logic [DATA_W-1:0]   xq_q;
	logic [DATA_W-1:0]   prev_x_q;
	logic [DATA_W-1:0]   prev_y_q;
	logic [DATA_W-1:0]   x1_q;
	logic [DATA_W-1:0]   y1_q;
	logic [DATA_W-1:0]   x2_q;
	logic [DATA_W-1:0]   y2_q;
	logic [DATA_W:0]     dy;
	logic [DATA_W:0]     dy_abs;
	logic [DATA_W:0]     span_w;
	logic [DATA_W:0]     off_w;
	logic [DATA_W-1:0]   mag_q;
	logic [DATA_W-1:0]   span_q;
	logic [DATA_W-1:0]   off_q;
	logic                neg_q;
	logic [WORD_W-1:0]   prod_q;
	logic                div_go_q;
	div_data_t           div_in;
	logic                div_out_valid;
	div_data_t           div_out;
	logic [DATA_W-1:0]   interp;
	logic                done_q;
	logic [DATA_W-1:0]   y_result_q;
	logic                status_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// clamp the entry count to the table depth
	always_comb begin
		if (32'(entries_in_use_q) > TABLE_DEPTH) begin
			n_c = CNT_W'(TABLE_DEPTH);
		end else begin
			n_c = CNT_W'(entries_in_use_q);
		end
	end

	// table RAM: loads write, the scan reads one entry ahead
	assign we    = accept && (func == FUNC_LOAD) && (32'(entry_index) < TABLE_DEPTH);
	assign waddr = ADDR_W'(entry_index);
	assign raddr = (state_q == ST_SCAN) ? ADDR_W'(chk_q + ADDR_W'(1)) : '0;

	tli_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({x_value, y_value}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// decode the entry under test
	assign cur_x    = rdata[WORD_W-1:DATA_W];
	assign cur_y    = rdata[DATA_W-1:0];
	assign is_last  = (32'(chk_q) + 1 == 32'(n_c));
	assign is_first = (chk_q == '0);
	assign above    = ($signed(cur_x) > $signed(xq_q));

	// operand preparation for the interpolation term
	always_comb begin
		dy     = {y2_q[DATA_W-1], y2_q} - {y1_q[DATA_W-1], y1_q};
		dy_abs = dy[DATA_W] ? (~dy + 1'b1) : dy;
		span_w = {x2_q[DATA_W-1], x2_q} - {x1_q[DATA_W-1], x1_q};
		off_w  = {xq_q[DATA_W-1], xq_q} - {x1_q[DATA_W-1], x1_q};
	end

	// divider row: high half of the product starts as the remainder
	always_comb begin
		div_in.rem  = prod_q[WORD_W-1:DATA_W];
		div_in.lo   = prod_q[DATA_W-1:0];
		div_in.span = span_q;
		div_in.neg  = neg_q;
		div_in.y1   = y1_q;
	end

	tli_div_chain u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_go_q),
		.in_data   (div_in),
		.out_valid (div_out_valid),
		.out_data  (div_out)
	);

	assign interp = div_out.neg ? (div_out.y1 - div_out.lo) : (div_out.y1 + div_out.lo);

	// sequencer and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			entries_in_use_q <= '0;
			chk_q            <= '0;
			div_go_q         <= 1'b0;
			done_q           <= 1'b0;
		end else begin
			if (entries_in_use_wr) begin
				entries_in_use_q <= entries_in_use;
			end
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_QUERY)) begin
						chk_q <= '0;
						if (n_c == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (is_last || (above && is_first)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (above) begin
						state_q <= ST_PREP;
					end else begin
						chk_q <= ADDR_W'(chk_q + ADDR_W'(1));
					end
				end
				ST_PREP: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					div_go_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_out_valid) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				xq_q       <= x_value;
				y_result_q <= '0;
				status_q   <= STATUS_EMPTY;
			end
			ST_SCAN: begin
				prev_x_q   <= cur_x;
				prev_y_q   <= cur_y;
				x1_q       <= prev_x_q;
				y1_q       <= prev_y_q;
				x2_q       <= cur_x;
				y2_q       <= cur_y;
				y_result_q <= cur_y;
				status_q   <= STATUS_OK;
			end
			ST_PREP: begin
				mag_q  <= dy_abs[DATA_W-1:0];
				neg_q  <= dy[DATA_W];
				span_q <= span_w[DATA_W-1:0];
				off_q  <= off_w[DATA_W-1:0];
			end
			ST_MUL: begin
				prod_q <= mag_q * off_q;
			end
			ST_DIV: begin
				y_result_q <= interp;
				status_q   <= STATUS_OK;
			end
			default: begin
				status_q <= STATUS_OK;
			end
		endcase
	end

	assign done     = done_q;
	assign y_result = y_result_q;
	assign status   = status_q;

endmodule

[hw/rtl/tli_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tli_div_cell.sv]
`timescale 1ns / 1ps
// One restoring division step: shift in a dividend bit, subtract if it fits.
// Depends on tli_pkg.
module tli_div_cell import tli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_data_t in_data,
	output logic      out_valid,
	output div_data_t out_data
);

	logic            valid_q;
	div_data_t       data_q;
	div_data_t       next_data;
	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic            fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial          = {in_data.rem, in_data.lo[DATA_W-1]};
		diff           = trial - {1'b0, in_data.span};
		fits           = (trial >= {1'b0, in_data.span});
		next_data      = in_data;
		next_data.rem  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		next_data.lo   = {in_data.lo[DATA_W-2:0], fits};
	end

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// hand the updated remainder and quotient bits to the next cell
	always_ff @(posedge clk) begin
		data_q <= next_data;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[hw/rtl/tli_div_chain.sv]
`timescale 1ns / 1ps
// Row of division cells, one quotient bit per cell, one cell per cycle.
// Depends on tli_pkg and tli_div_cell.
module tli_div_chain import tli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_data_t in_data,
	output logic      out_valid,
	output div_data_t out_data
);

	logic      tap_valid [DIV_STEPS+1];
	div_data_t tap_data  [DIV_STEPS+1];

	assign tap_valid[0] = in_valid;
	assign tap_data[0]  = in_data;

	// chain the cells
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
		tli_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (tap_valid[k]),
			.in_data   (tap_data[k]),
			.out_valid (tap_valid[k+1]),
			.out_data  (tap_data[k+1])
		);
	end

	assign out_valid = tap_valid[DIV_STEPS];
	assign out_data  = tap_data[DIV_STEPS];

endmodule

[hw/rtl/tli_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for table_linear_interpolator, attached by bind.
// Depends on tli_pkg and the top level's ports.
module tli_checker import tli_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              func,
	input logic              done,
	input logic [DATA_W-1:0] y_result,
	input logic              status
);

	// a query either finishes at once or holds the block busy
	a_query_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_QUERY) |=> busy || done)
		else $error("query transaction neither started nor finished");

	// a load causes no result and leaves the block free
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_LOAD) |=> !done && !busy)
		else $error("load transaction produced a result or stalled");

	// a result is never shown while a query is still at work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the end of a busy query (scan or division) always delivers a valid result
	a_end_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && (status == STATUS_OK))
		else $error("busy dropped without a valid result");

	// empty-table status comes with a zero value
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_EMPTY) |-> (y_result == '0))
		else $error("empty-table result is not zero");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (.*);

[sim/tb_table_linear_interpolator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for table_linear_interpolator: loads breakpoint tables,
// queries them and checks each result against a built-in interpolation predictor.
// Depends on tli_pkg and the table_linear_interpolator RTL.
module tb_table_linear_interpolator;
	import tli_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 1050;

	typedef struct packed {
		logic [DATA_W-1:0] y;
		logic              status;
	} interp_result_t;

	// Interpolation predictor plus the queue of query results still owed
	class lerp_checker;
		logic [DATA_W-1:0] bp_x [TABLE_DEPTH];
		logic [DATA_W-1:0] bp_y [TABLE_DEPTH];
		logic [CFG_W-1:0]  entry_count;
		interp_result_t    expected_q [$];
		int                mismatches;

		function new();
			entry_count = '0;
			mismatches = 0;
		endfunction

		function void set_entry_count(logic [CFG_W-1:0] n);
			entry_count = n;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// y1 + trunc(dy * off / span), done on 64-bit magnitudes
		function logic [DATA_W-1:0] lerp(int lo, int hi, longint xq);
			longint x1, x2, y1, y2, dy, r;
			bit [63:0] span, off, mag, q;
			x1 = $signed(bp_x[lo]);
			x2 = $signed(bp_x[hi]);
			y1 = $signed(bp_y[lo]);
			y2 = $signed(bp_y[hi]);
			dy = y2 - y1;
			span = x2 - x1;
			off = xq - x1;
			if (span == 0)
				return bp_y[lo];
			mag = (dy < 0) ? -dy : dy;
			q = (mag * off) / span;
			r = (dy < 0) ? y1 - longint'(q) : y1 + longint'(q);
			return r[DATA_W-1:0];
		endfunction

		function interp_result_t predict(logic [DATA_W-1:0] xq);
			interp_result_t res;
			int n, i;
			n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
			res.status = STATUS_OK;
			if (n == 0) begin
				res.y = '0;
				res.status = STATUS_EMPTY;
				return res;
			end
			// find the first entry above the query
			i = 0;
			while (i < n && $signed(bp_x[i]) <= $signed(xq))
				i++;
			if (i >= n - 1)
				res.y = bp_y[n-1];
			else if (i == 0)
				res.y = bp_y[0];
			else
				res.y = lerp(i - 1, i, $signed(xq));
			return res;
		endfunction

		function void note_item(logic f, logic [7:0] idx, logic [DATA_W-1:0] xv,
				logic [DATA_W-1:0] yv);
			if (f == FUNC_LOAD) begin
				if (idx < TABLE_DEPTH) begin
					bp_x[idx] = xv;
					bp_y[idx] = yv;
				end
			end else begin
				expected_q.push_back(predict(xv));
			end
		endfunction

		function void check_result(logic [DATA_W-1:0] y, logic st);
			interp_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected result: y_result %h status %b", y, st);
				mismatches++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (y !== exp_r.y) begin
				$error("y_result: expected %h, actual %h", exp_r.y, y);
				mismatches++;
			end
			if (st !== exp_r.status) begin
				$error("status: expected %b, actual %b", exp_r.status, st);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              entries_in_use_wr;
	logic [CFG_W-1:0]  entries_in_use;
	logic              start;
	logic              busy;
	logic              func;
	logic [7:0]        entry_index;
	logic [DATA_W-1:0] x_value;
	logic [DATA_W-1:0] y_value;
	logic              done;
	logic [DATA_W-1:0] y_result;
	logic              status;

	lerp_checker sb;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          at_fall = 1'b0;
	int          idle_cycles = 0;

	table_linear_interpolator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.entries_in_use_wr(entries_in_use_wr),
		.entries_in_use   (entries_in_use),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.entry_index      (entry_index),
		.x_value          (x_value),
		.y_value          (y_value),
		.done             (done),
		.y_result         (y_result),
		.status           (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result strobe against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(y_result, status);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one transaction, hold it until accepted, then idle per burst pattern
	task automatic drive_transaction(logic f, logic [7:0] idx, logic [DATA_W-1:0] xv,
			logic [DATA_W-1:0] yv);
		int gap;
		if (!at_fall)
			@(negedge clk);
		start <= 1'b1;
		func <= f;
		entry_index <= idx;
		x_value <= xv;
		y_value <= yv;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(f, idx, xv, yv);
		items_sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end else begin
			burst_left--;
		end
		at_fall = 1'b1;
	endtask

	// Drop start if the last transaction left it high
	task automatic settle();
		if (at_fall) begin
			start <= 1'b0;
			at_fall = 1'b0;
		end
	endtask

	task automatic load_breakpoint(logic [7:0] idx, logic [DATA_W-1:0] xv,
			logic [DATA_W-1:0] yv);
		drive_transaction(FUNC_LOAD, idx, xv, yv);
	endtask

	task automatic query_point(logic [DATA_W-1:0] xq);
		drive_transaction(FUNC_QUERY, 8'($urandom), xq, $urandom);
	endtask

	// Write the entry count once the block has drained
	task automatic set_entry_count(logic [CFG_W-1:0] n);
		settle();
		while (sb.outstanding() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		entries_in_use_wr <= 1'b1;
		entries_in_use <= n;
		@(posedge clk);
		sb.set_entry_count(n);
		@(negedge clk);
		entries_in_use_wr <= 1'b0;
	endtask

	// Fill entries 0..m-1: mostly sorted x, sometimes narrow, duplicated or unsorted
	task automatic build_table(int m);
		int vals [$];
		int mode, shift;
		logic [DATA_W-1:0] yv;
		mode = $urandom_range(0, 3);
		shift = $urandom_range(0, 15);
		for (int k = 0; k < m; k++) begin
			case (mode)
				1: vals.push_back((int'($urandom_range(0, 65535)) - 32768) <<< shift);
				3: vals.push_back(int'($urandom_range(0, 7)) * 1000 - 3000);
				default: vals.push_back($urandom);
			endcase
		end
		if (mode != 2)
			vals.sort();
		for (int k = 0; k < m; k++) begin
			yv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) - 128 : $urandom;
			load_breakpoint(k[7:0], vals[k], yv);
		end
	endtask

	// Pick a query x: mostly inside a segment of the current table
	function automatic logic [DATA_W-1:0] pick_query_x(int m);
		int xs [$];
		int sel, j;
		longint lo, hi, t;
		sel = $urandom_range(0, 99);
		if (m == 0 || sel < 10) begin
			case (sel % 3)
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				default: return $urandom;
			endcase
		end
		for (int k = 0; k < m; k++)
			xs.push_back($signed(sb.bp_x[k]));
		xs.sort();
		if (sel < 25)
			return xs[$urandom_range(0, m - 1)];
		if (sel < 30) begin
			t = longint'(xs[0]) - 1 - longint'($urandom_range(0, 1000));
			if (t < -64'sd2147483648)
				t = -64'sd2147483648;
			return t[DATA_W-1:0];
		end
		if (sel < 38 || m < 2)
			return $urandom;
		j = $urandom_range(0, m - 2);
		lo = xs[j];
		hi = xs[j+1];
		if (hi == lo)
			return lo[DATA_W-1:0];
		t = lo + longint'($urandom) % (hi - lo);
		return t[DATA_W-1:0];
	endfunction

	initial begin
		int phase, n, m, nq;
		sb = new();
		arst_n = 1'b0;
		entries_in_use_wr = 1'b0;
		entries_in_use = '0;
		start = 1'b0;
		func = FUNC_LOAD;
		entry_index = '0;
		x_value = '0;
		y_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table straight after reset and after an explicit zero count
		query_point(32'h8000_0000);
		set_entry_count(0);
		query_point(32'h7FFF_FFFF);

		// table spanning the full x and y range
		load_breakpoint(8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		load_breakpoint(8'd1, 32'h0000_0000, 32'h8000_0000);
		load_breakpoint(8'd2, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
		load_breakpoint(8'd3, 32'h7FFF_FFFF, 32'h0000_0000);
		load_breakpoint(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_entry_count(4);
		query_point(32'h8000_0000);
		query_point(32'hC000_0000);
		query_point(32'hFFFF_FFFF);
		query_point(32'h0000_0000);
		query_point(32'h7FFF_FFFD);
		// first greater is the last entry, then no greater entry at all
		query_point(32'h7FFF_FFFE);
		query_point(32'h7FFF_FFFF);

		// query below the first breakpoint clamps to the first y
		load_breakpoint(8'd0, 32'h8000_0001, 32'h1234_5678);
		query_point(32'h8000_0000);

		// single and two-entry tables never interpolate
		set_entry_count(1);
		query_point(32'h0000_0000);
		set_entry_count(2);
		query_point(32'h8000_0000);
		query_point(32'h4000_0000);
		query_point(32'hFFFF_0000);

		// random phases: new count, fresh table, queries with stray loads
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 2)
				n = 511;
			else if (phase == 3)
				n = 256;
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(0, 2);
			else
				n = $urandom_range(3, 24);
			set_entry_count(n[CFG_W-1:0]);
			m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
			// the full-depth count reuses the table loaded for the oversized one
			if (phase != 3 && m > 0)
				build_table(m);
			if (m == 0)
				nq = $urandom_range(2, 4);
			else if (m >= 200)
				nq = $urandom_range(15, 25);
			else
				nq = $urandom_range(10, 40);
			repeat (nq) begin
				if ($urandom_range(0, 9) == 0)
					load_breakpoint(8'($urandom_range(0, 255)), $urandom, $urandom);
				query_point(pick_query_x(m));
			end
			phase++;
		end

		// drain, then give a late stray result time to show up
		settle();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
